/* design/bpc_pkg.sv */
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants for the button press classifier
// Command codes, register indexes, register reset values and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

  // command codes carried with each input word
  typedef enum logic [1:0] {
    CMD_POLL        = 2'd0,
    CMD_TAKE_SHORT  = 2'd1,
    CMD_TAKE_REPEAT = 2'd2,
    CMD_TAKE_LONG   = 2'd3
  } cmd_t;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_MASK    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SHORT_TICKS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_START  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_TICKS  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOW_PERIOD = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FAST_PERIOD = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOW_LIMIT  = 3'd6;

  localparam int unsigned CFG_DATA_W = 16;

  // register reset values
  localparam logic [15:0] KEY_MASK_RST    = 16'd1;
  localparam logic [15:0] SHORT_TICKS_RST = 16'd10;
  localparam logic [15:0] HOLD_START_RST  = 16'd100;
  localparam logic [15:0] LONG_TICKS_RST  = 16'd3000;
  localparam logic [15:0] SLOW_PERIOD_RST = 16'd300;
  localparam logic [15:0] FAST_PERIOD_RST = 16'd120;
  localparam logic [7:0]  SLOW_LIMIT_RST  = 8'd6;

  localparam logic [15:0] POLL_COUNT_MAX = 16'hFFFF;

  // one result word
  typedef struct packed {
    logic taken;
    logic is_pressed;
    logic short_pending;
    logic repeat_pending;
    logic long_pending;
  } result_t;

endpackage

`default_nettype wire

/* design/button_press_classifier.sv */
// ----------------------------------------------------------------------------
// button_press_classifier: short, long and auto-repeat press detection
// Classifies one button from polled active-low key words and keeps sticky
// flags that take commands read and clear.
// ----------------------------------------------------------------------------
// a result word is registered into the result buffer when its input word is accepted
// throughput: one word per cycle while in_stall is low; state update is a single compare/add pass
// a two-entry result buffer lets input run on while one result waits
// reset: synchronous rst clears state, flags and buffer, loads register defaults
`default_nettype none

module button_press_classifier import bpc_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration write port
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             command,
  input  wire logic [15:0]            raw_keys,
  input  wire logic                   read_ok,
  input  wire logic [31:0]            now_tick,
  // output channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        taken,
  output logic                        is_pressed,
  output logic                        short_pending,
  output logic                        repeat_pending,
  output logic                        long_pending
);

  // configuration registers
  logic [15:0] key_mask;
  logic [15:0] short_ticks;
  logic [15:0] hold_start_ticks;
  logic [15:0] long_ticks;
  logic [15:0] slow_period_polls;
  logic [15:0] fast_period_polls;
  logic [7:0]  slow_repeat_limit;

  // classifier state
  logic [31:0] press_tick,   press_tick_next;
  logic        prev_pressed, prev_pressed_next;
  logic [15:0] poll_count,   poll_count_next;
  logic [7:0]  repeat_count, repeat_count_next;
  logic        short_flag,   short_flag_next;
  logic        repeat_flag,  repeat_flag_next;
  logic        long_flag,    long_flag_next;
  logic        taken_next;

  // result buffer
  result_t     res_buf [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  logic        in_accept;
  logic        out_accept;

  // poll datapath
  logic        pressed;
  logic [31:0] press_tick_eff;
  logic [31:0] elapsed;
  logic        counting;
  logic [15:0] poll_inc;
  logic        slow_fire;
  logic        fast_fire;
  cmd_t        cmd;

  assign cmd        = cmd_t'(command);
  assign in_stall   = (count == 2'd2);
  assign in_accept  = in_valid && !in_stall;
  assign out_valid  = (count != 2'd0);
  assign out_accept = out_valid && !out_stall;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      key_mask          <= KEY_MASK_RST;
      short_ticks       <= SHORT_TICKS_RST;
      hold_start_ticks  <= HOLD_START_RST;
      long_ticks        <= LONG_TICKS_RST;
      slow_period_polls <= SLOW_PERIOD_RST;
      fast_period_polls <= FAST_PERIOD_RST;
      slow_repeat_limit <= SLOW_LIMIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KEY_MASK:    key_mask          <= cfg_data;
        REG_SHORT_TICKS: short_ticks       <= cfg_data;
        REG_HOLD_START:  hold_start_ticks  <= cfg_data;
        REG_LONG_TICKS:  long_ticks        <= cfg_data;
        REG_SLOW_PERIOD: slow_period_polls <= cfg_data;
        REG_FAST_PERIOD: fast_period_polls <= cfg_data;
        REG_SLOW_LIMIT:  slow_repeat_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // press detection and held time
  assign pressed        = read_ok && ((raw_keys & key_mask) == 16'd0);
  assign press_tick_eff = (pressed && !prev_pressed) ? now_tick : press_tick;
  assign elapsed        = now_tick - press_tick_eff;
  assign counting       = pressed && (elapsed > {16'd0, hold_start_ticks});

  // repeat timing, saturating poll counter
  assign poll_inc  = (poll_count == POLL_COUNT_MAX) ? poll_count : poll_count + 16'd1;
  assign slow_fire = (poll_inc == slow_period_polls) && (repeat_count < slow_repeat_limit);
  assign fast_fire = !slow_fire && (poll_inc == fast_period_polls)
                     && (repeat_count >= slow_repeat_limit);

  // next state per command
  always_comb begin
    press_tick_next   = press_tick;
    prev_pressed_next = prev_pressed;
    poll_count_next   = poll_count;
    repeat_count_next = repeat_count;
    short_flag_next   = short_flag;
    repeat_flag_next  = repeat_flag;
    long_flag_next    = long_flag;
    taken_next        = 1'b0;
    case (cmd)
      CMD_POLL: begin
        press_tick_next   = press_tick_eff;
        prev_pressed_next = pressed;
        if (pressed && (elapsed == {16'd0, short_ticks})) begin
          short_flag_next = 1'b1;
        end
        if (pressed && (elapsed == {16'd0, long_ticks})) begin
          long_flag_next = 1'b1;
        end
        if (counting) begin
          poll_count_next = poll_inc;
          if (slow_fire) begin
            repeat_flag_next  = 1'b1;
            poll_count_next   = 16'd0;
            repeat_count_next = repeat_count + 8'd1;
          end else if (fast_fire) begin
            repeat_flag_next = 1'b1;
            poll_count_next  = 16'd0;
          end
        end else begin
          poll_count_next   = 16'd0;
          repeat_count_next = 8'd0;
          repeat_flag_next  = 1'b0;
        end
      end
      CMD_TAKE_SHORT: begin
        taken_next      = short_flag;
        short_flag_next = 1'b0;
      end
      CMD_TAKE_REPEAT: begin
        taken_next       = repeat_flag;
        repeat_flag_next = 1'b0;
      end
      CMD_TAKE_LONG: begin
        taken_next     = long_flag;
        long_flag_next = 1'b0;
      end
      default: ;
    endcase
  end

  // state update on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      press_tick   <= 32'd0;
      prev_pressed <= 1'b0;
      poll_count   <= 16'd0;
      repeat_count <= 8'd0;
      short_flag   <= 1'b0;
      repeat_flag  <= 1'b0;
      long_flag    <= 1'b0;
    end else if (in_accept) begin
      press_tick   <= press_tick_next;
      prev_pressed <= prev_pressed_next;
      poll_count   <= poll_count_next;
      repeat_count <= repeat_count_next;
      short_flag   <= short_flag_next;
      repeat_flag  <= repeat_flag_next;
      long_flag    <= long_flag_next;
    end
  end

  // result buffer payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_buf[wr_ptr] <= '{taken:          taken_next,
                           is_pressed:     prev_pressed_next,
                           short_pending:  short_flag_next,
                           repeat_pending: repeat_flag_next,
                           long_pending:   long_flag_next};
    end
  end

  // result buffer pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (in_accept) begin
        wr_ptr <= !wr_ptr;
      end
      if (out_accept) begin
        rd_ptr <= !rd_ptr;
      end
      case ({in_accept, out_accept})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign taken          = res_buf[rd_ptr].taken;
  assign is_pressed     = res_buf[rd_ptr].is_pressed;
  assign short_pending  = res_buf[rd_ptr].short_pending;
  assign repeat_pending = res_buf[rd_ptr].repeat_pending;
  assign long_pending   = res_buf[rd_ptr].long_pending;

endmodule

`default_nettype wire

/* test/button_press_classifier_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_classifier_tb: self-checking bench for the press classifier
// A short directed table at the reset register values, then random press and
// release gestures under several register settings and handshake idling mixes.
// Each result word is checked field by field against the table or the predictor.
// ----------------------------------------------------------------------------

module button_press_classifier_tb;
  import bpc_pkg::*;

  localparam int QUIET_LIMIT    = 4000;
  localparam int PHASE_WORDS    = 225;
  localparam int ZERO_PER_POLLS = 60;
  localparam int PRINT_CAP      = 40;

  // one full set of register values
  typedef struct {
    logic [15:0] mask;
    logic [15:0] short_at;
    logic [15:0] hold_after;
    logic [15:0] long_at;
    logic [15:0] slow_per;
    logic [15:0] fast_per;
    logic [7:0]  slow_max;
  } cfg_set_t;

  // one row of the directed table
  typedef struct {
    cmd_t        cmd;
    logic [15:0] keys;
    logic        ok;
    logic [31:0] tick;
    logic        typed;
    result_t     want;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_KEY_MASK;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = CMD_POLL;
  logic [15:0] raw_keys = 16'h0000;
  logic        read_ok = 1'b0;
  logic [31:0] now_tick = 32'h0000_0000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        taken;
  logic        is_pressed;
  logic        short_pending;
  logic        repeat_pending;
  logic        long_pending;

  // predictor copy of registers and state
  cfg_set_t    live_cfg;
  logic [31:0] press_origin = 32'h0000_0000;
  logic        held_before = 1'b0;
  logic [15:0] held_polls = 16'h0000;
  logic [7:0]  repeats_fired = 8'h00;
  logic        short_sticky = 1'b0;
  logic        repeat_sticky = 1'b0;
  logic        long_sticky = 1'b0;

  result_t     flag_reports[$];
  int          send_gap_pct = 0;
  int          stall_pct = 0;
  int          words_sent = 0;
  int          reports_checked = 0;
  int          takes_hit = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  logic [31:0] wall_tick;

  cfg_set_t palette [4] = '{
    '{16'h0001, 16'd3,     16'd4,     16'd12,    16'd3, 16'd3, 8'd2},
    '{16'hA5F0, 16'd0,     16'd0,     16'd0,     16'd1, 16'd1, 8'd0},
    '{16'h0000, 16'd5,     16'd2,     16'd30,    16'd4, 16'd3, 8'd255},
    '{16'hFFFF, 16'hFFFF,  16'hFFFF,  16'hFFFF,  16'd0, 16'd0, 8'd1}
  };

  // directed table, run with the register reset values
  step_row_t script [23] = '{
    '{CMD_TAKE_SHORT,  16'h0000, 1'b1, 32'd0,         1'b1, 5'b00000},
    '{CMD_TAKE_REPEAT, 16'h0000, 1'b1, 32'd0,         1'b1, 5'b00000},
    '{CMD_TAKE_LONG,   16'h0000, 1'b1, 32'd0,         1'b1, 5'b00000},
    '{CMD_POLL,        16'hFFFF, 1'b1, 32'd0,         1'b1, 5'b00000},
    '{CMD_POLL,        16'h0000, 1'b0, 32'd5,         1'b1, 5'b00000},
    '{CMD_POLL,        16'hFFFE, 1'b1, 32'd100,       1'b1, 5'b01000},
    '{CMD_POLL,        16'hFFFE, 1'b1, 32'd110,       1'b1, 5'b01100},
    '{CMD_POLL,        16'h0000, 1'b1, 32'd201,       1'b1, 5'b01100},
    '{CMD_TAKE_SHORT,  16'hFFFF, 1'b0, 32'd0,         1'b1, 5'b11000},
    '{CMD_TAKE_SHORT,  16'hFFFF, 1'b0, 32'd0,         1'b1, 5'b01000},
    '{CMD_POLL,        16'h0000, 1'b1, 32'd3100,      1'b1, 5'b01001},
    '{CMD_TAKE_LONG,   16'hFFFF, 1'b0, 32'hFFFF_FFFF, 1'b1, 5'b11000},
    '{CMD_POLL,        16'hFFFE, 1'b1, 32'hFFFF_FFFF, 1'b1, 5'b01000},
    '{CMD_POLL,        16'h0001, 1'b1, 32'd0,         1'b1, 5'b00000},
    '{CMD_POLL,        16'hFFFE, 1'b1, 32'hFFFF_FFFA, 1'b1, 5'b01000},
    '{CMD_POLL,        16'h7FFE, 1'b1, 32'd4,         1'b1, 5'b01100},
    '{CMD_POLL,        16'h0000, 1'b0, 32'd5,         1'b1, 5'b00100},
    '{CMD_TAKE_REPEAT, 16'h0000, 1'b1, 32'd5,         1'b1, 5'b00100},
    '{CMD_TAKE_LONG,   16'h0000, 1'b1, 32'd5,         1'b1, 5'b00100},
    '{CMD_TAKE_SHORT,  16'h0000, 1'b1, 32'd5,         1'b1, 5'b10000},
    '{CMD_POLL,        16'hFFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 5'b00000},
    '{CMD_POLL,        16'h8000, 1'b1, 32'd20,        1'b0, 5'b00000},
    '{CMD_POLL,        16'hFFFE, 1'b1, 32'd3020,      1'b0, 5'b00000}
  };

  button_press_classifier DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .raw_keys       (raw_keys),
    .read_ok        (read_ok),
    .now_tick       (now_tick),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .taken          (taken),
    .is_pressed     (is_pressed),
    .short_pending  (short_pending),
    .repeat_pending (repeat_pending),
    .long_pending   (long_pending)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // flag and press state after one word, updating the predictor state
  task automatic classify_press(input cmd_t c, input logic [15:0] k, input logic ok,
                                input logic [31:0] t, output result_t r);
    logic        down;
    logic [31:0] held;
    r = '0;
    case (c)
      CMD_POLL: begin
        down = ok && ((k & live_cfg.mask) == 16'h0000);
        if (down && !held_before) press_origin = t;
        held = t - press_origin;
        if (down && held == {16'h0000, live_cfg.short_at}) short_sticky = 1'b1;
        // repeat polls only count once the hold start time has passed
        if (down && held > {16'h0000, live_cfg.hold_after}) begin
          if (held_polls != POLL_COUNT_MAX) held_polls = held_polls + 16'd1;
          if (held_polls == live_cfg.slow_per && repeats_fired < live_cfg.slow_max) begin
            repeat_sticky = 1'b1;
            held_polls = 16'h0000;
            repeats_fired = repeats_fired + 8'd1;
          end else if (held_polls == live_cfg.fast_per &&
                       repeats_fired >= live_cfg.slow_max) begin
            repeat_sticky = 1'b1;
            held_polls = 16'h0000;
          end
        end else begin
          repeats_fired = 8'h00;
          held_polls = 16'h0000;
          repeat_sticky = 1'b0;
        end
        if (down && held == {16'h0000, live_cfg.long_at}) long_sticky = 1'b1;
        held_before = down;
      end
      CMD_TAKE_SHORT: begin
        r.taken = short_sticky;
        short_sticky = 1'b0;
      end
      CMD_TAKE_REPEAT: begin
        r.taken = repeat_sticky;
        repeat_sticky = 1'b0;
      end
      default: begin
        r.taken = long_sticky;
        long_sticky = 1'b0;
      end
    endcase
    r.is_pressed = held_before;
    r.short_pending = short_sticky;
    r.repeat_pending = repeat_sticky;
    r.long_pending = long_sticky;
  endtask

  // offer one word, wait for it to be taken, then queue its expected result
  task automatic send_word(input cmd_t c, input logic [15:0] k, input logic ok,
                           input logic [31:0] t, input logic typed, input result_t want);
    result_t r;
    while (int'($urandom_range(99)) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= c;
    raw_keys <= k;
    read_ok  <= ok;
    now_tick <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    classify_press(c, k, ok, t, r);
    flag_reports.push_back(typed ? want : r);
    words_sent++;
  endtask

  // drop valid and wait until every expected word has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (flag_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // write all registers while the block is idle
  task automatic load_settings(input cfg_set_t s);
    settle();
    put_reg(REG_KEY_MASK, s.mask);
    put_reg(REG_SHORT_TICKS, s.short_at);
    put_reg(REG_HOLD_START, s.hold_after);
    put_reg(REG_LONG_TICKS, s.long_at);
    put_reg(REG_SLOW_PERIOD, s.slow_per);
    put_reg(REG_FAST_PERIOD, s.fast_per);
    put_reg(REG_SLOW_LIMIT, {8'($urandom), s.slow_max});
    cfg_write <= 1'b0;
    live_cfg = s;
  endtask

  // release and hold gestures with random content, plus some noise words
  task automatic play_gestures(input int budget);
    int          sent;
    int          span;
    int          pick;
    logic [31:0] origin;
    logic [15:0] k;
    logic        ok;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(99) < 10) begin
        send_word(cmd_t'($urandom_range(3)), 16'($urandom), 1'($urandom), $urandom,
                  1'b0, '0);
        sent++;
      end else begin
        // let go for a few polls, sometimes through a failed read
        repeat ($urandom_range(3, 1)) begin
          k = 16'($urandom);
          if ((k & live_cfg.mask) == 16'h0000) k = k | live_cfg.mask;
          ok = !(live_cfg.mask == 16'h0000 || $urandom_range(3) == 0);
          wall_tick = wall_tick + $urandom_range(5);
          send_word(CMD_POLL, k, ok, wall_tick, 1'b0, '0);
          sent++;
        end
        // hold, sometimes starting just below the tick wrap
        if ($urandom_range(19) == 0) wall_tick = 32'hFFFF_FFF0 + $urandom_range(15);
        origin = wall_tick + 32'd1;
        wall_tick = origin;
        span = ($urandom_range(9) == 0) ? $urandom_range(300, 100) : $urandom_range(40, 1);
        for (int i = 0; i < span; i++) begin
          if ($urandom_range(99) < 15) begin
            send_word(cmd_t'($urandom_range(3, 1)), 16'($urandom), 1'($urandom),
                      $urandom, 1'b0, '0);
            sent++;
          end
          k = 16'($urandom) & ~live_cfg.mask;
          ok = 1'b1;
          // rare glitch inside a hold
          if ($urandom_range(99) < 4) begin
            k = 16'($urandom);
            ok = 1'($urandom);
          end
          send_word(CMD_POLL, k, ok, wall_tick, 1'b0, '0);
          sent++;
          // advance time, sometimes landing right on a threshold
          pick = $urandom_range(99);
          if (pick < 55) wall_tick = wall_tick + 32'd1;
          else if (pick < 68) wall_tick = wall_tick;
          else if (pick < 80) wall_tick = wall_tick + $urandom_range(5, 2);
          else if (pick < 94) begin
            case ($urandom_range(3))
              0: wall_tick = origin + {16'h0000, live_cfg.short_at};
              1: wall_tick = origin + {16'h0000, live_cfg.long_at};
              2: wall_tick = origin + {16'h0000, live_cfg.hold_after};
              default: wall_tick = origin + {16'h0000, live_cfg.hold_after} + 32'd1;
            endcase
          end else wall_tick = $urandom;
        end
      end
    end
  endtask

  // receiver stalls
  always @(posedge clk) begin
    out_stall <= (int'($urandom_range(99)) < stall_pct);
  end

  task automatic compare_bit(input string field, input logic want, input logic got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= PRINT_CAP)
        $display("%0t ns: %s mismatch, expected %b got %b", $time, field, want, got);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst && out_valid && !out_stall) begin
      got = {taken, is_pressed, short_pending, repeat_pending, long_pending};
      if (flag_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= PRINT_CAP)
          $display("%0t ns: result word with none expected, expected none got %b",
                   $time, got);
      end else begin
        want = flag_reports.pop_front();
        compare_bit("taken", want.taken, got.taken);
        compare_bit("is_pressed", want.is_pressed, got.is_pressed);
        compare_bit("short_pending", want.short_pending, got.short_pending);
        compare_bit("repeat_pending", want.repeat_pending, got.repeat_pending);
        compare_bit("long_pending", want.long_pending, got.long_pending);
        reports_checked++;
        if (want.taken) takes_hit++;
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no progress, %0d words still expected", $time, flag_reports.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // main sequence
  initial begin
    cfg_set_t    sat;
    logic [31:0] base;
    live_cfg = '{KEY_MASK_RST, SHORT_TICKS_RST, HOLD_START_RST, LONG_TICKS_RST,
                 SLOW_PERIOD_RST, FAST_PERIOD_RST, SLOW_LIMIT_RST};
    wall_tick = $urandom;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed table with reset register values
    foreach (script[i])
      send_word(script[i].cmd, script[i].keys, script[i].ok, script[i].tick,
                script[i].typed, script[i].want);

    // random gestures: settings and idling mixes rotate per phase
    for (int p = 0; p < 8; p++) begin
      load_settings(palette[(p + p / 4) % 4]);
      case (p % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 58; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 58; end
        default: begin send_gap_pct = 27; stall_pct = 27; end
      endcase
      play_gestures(PHASE_WORDS);
    end

    // zero periods never fire while the poll count keeps running
    send_gap_pct = 0;
    stall_pct = 0;
    sat = '{16'h0001, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 8'd0};
    load_settings(sat);
    base = $urandom;
    send_word(CMD_POLL, 16'hFFFF, 1'b1, base, 1'b0, '0);
    send_word(CMD_POLL, 16'hFFFE, 1'b1, base, 1'b0, '0);
    repeat (ZERO_PER_POLLS)
      send_word(CMD_POLL, 16'($urandom) & 16'hFFFE, 1'b1, base + 32'd1, 1'b0, '0);
    // the running count then meets a fast period set one above it
    sat.fast_per = 16'(ZERO_PER_POLLS + 1);
    load_settings(sat);
    send_word(CMD_POLL, 16'h0000, 1'b1, base + 32'd1, 1'b0, '0);
    send_word(CMD_TAKE_REPEAT, 16'h0000, 1'b1, base, 1'b0, '0);
    send_word(CMD_POLL, 16'hFFFF, 1'b0, base + 32'd2, 1'b0, '0);

    settle();
    repeat (10) @(posedge clk);
    $display("covered %0d input words: directed table, eight setting and idling phases,",
             words_sent);
    $display("and a zero period pass; %0d results checked, %0d takes found a flag",
             reports_checked, takes_hit);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/bpc_pkg.sv
design/button_press_classifier.sv
test/button_press_classifier_tb.sv
